// File: design/ccq_pkg.sv
`default_nettype none

package ccq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned QueueDepthDef  = 12;
  localparam int unsigned KeyBitsDef     = 8;
  localparam int unsigned PayloadBitsDef = 32;

  // Fixed field widths of the channel payloads
  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned KeyIdW   = 8;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned CountW   = 4;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_POP     = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_e;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [KeyIdW-1:0]   key_id;
    logic [PayloadW-1:0] payload_word;
  } in_t;

  typedef struct packed {
    logic                accepted;
    logic                head_valid;
    logic [KeyIdW-1:0]   head_key;
    logic [PayloadW-1:0] head_payload;
    logic [CountW-1:0]   entry_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic apply;
    logic rd_head;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/ccq_ram.sv
`default_nettype none

module ccq_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/ccq_ctrl.sv
`default_nettype none

module ccq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ccq_pkg::dp_stat_t   st_i,
  output ccq_pkg::ctl_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_RD_HEAD,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;

  always_comb begin
    state_d = state_q;
    rdy_d   = rdy_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.capture = 1'b1;
          rdy_d         = 1'b0;
          state_d       = st_i.need_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_RD_HEAD;
      end
      ST_RD_HEAD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          rdy_d          = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        rdy_d   = 1'b1;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
    end
  end

  assign in_ready_o = rdy_q;

endmodule

`default_nettype wire

// File: design/ccq_datapath.sv
`default_nettype none

module ccq_datapath #(
  parameter int unsigned QueueDepth  = ccq_pkg::QueueDepthDef,
  parameter int unsigned KeyBits     = ccq_pkg::KeyBitsDef,
  parameter int unsigned PayloadBits = ccq_pkg::PayloadBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ccq_pkg::in_t       in_data_i,
  input  wire ccq_pkg::ctl_cmd_t  cmd_i,
  output ccq_pkg::dp_stat_t       st_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ccq_pkg::out_t           out_data_o
);

  localparam int unsigned SlotW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned SumW  = SlotW + 2;
  localparam int unsigned AddrW = SlotW + 1;
  localparam int unsigned EntW  = KeyBits + PayloadBits;
  localparam int unsigned KeyFw = ccq_pkg::KeyIdW;
  localparam int unsigned PayFw = ccq_pkg::PayloadW;
  localparam int unsigned CntFw = ccq_pkg::CountW;
  localparam logic [SumW-1:0] DepthS = SumW'(QueueDepth);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);

  ccq_pkg::in_t  req_q;
  ccq_pkg::out_t out_q, out_d;

  logic [SlotW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             bank_q, bank_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  kept_q, kept_d;
  logic             pend_q, pend_d;
  logic             acc_q, acc_d;
  logic             out_valid_q, out_valid_d;

  logic [SumW-1:0]  src_sum, tail_sum, next_sum;
  logic [SlotW-1:0] src_slot, tail_slot, next_slot;
  logic [KeyBits-1:0]     key_in, key_rd;
  logic [PayloadBits-1:0] pay_in, pay_rd;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;

  assign key_in = KeyBits'(req_q.key_id);
  assign pay_in = PayloadBits'(req_q.payload_word);
  assign key_rd = ram_rdata[EntW-1:PayloadBits];
  assign pay_rd = ram_rdata[PayloadBits-1:0];

  // Circular slot arithmetic: the head stays below the depth and the other operand is at most the depth
  always_comb begin
    src_sum   = SumW'(head_q) + SumW'(rd_idx_q);
    src_slot  = (src_sum >= DepthS) ? SlotW'(src_sum - DepthS) : SlotW'(src_sum);
    tail_sum  = SumW'(head_q) + SumW'(count_q);
    tail_slot = (tail_sum >= DepthS) ? SlotW'(tail_sum - DepthS) : SlotW'(tail_sum);
    next_sum  = SumW'(head_q) + SumW'(1);
    next_slot = (next_sum >= DepthS) ? SlotW'(next_sum - DepthS) : SlotW'(next_sum);
  end

  assign st_o.need_scan = (in_data_i.req_type == ccq_pkg::REQ_ENQUEUE) && (count_q != '0);
  assign st_o.scan_done = (rd_idx_q == count_q) && !pend_q;
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    bank_d      = bank_q;
    rd_idx_d    = rd_idx_q;
    kept_d      = kept_q;
    pend_d      = 1'b0;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = {bank_q, tail_slot};
    ram_wdata   = {key_in, pay_in};
    ram_re      = 1'b0;
    ram_raddr   = {bank_q, head_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.capture) begin
      rd_idx_d = '0;
      kept_d   = '0;
    end

    // Stream live entries out of the current bank, copy survivors to the other
    if (cmd_i.scan) begin
      if (rd_idx_q != count_q) begin
        ram_re    = 1'b1;
        ram_raddr = {bank_q, src_slot};
        rd_idx_d  = rd_idx_q + CntW'(1);
        pend_d    = 1'b1;
      end
      if (pend_q && (key_rd != key_in)) begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_q, SlotW'(kept_q)};
        ram_wdata = ram_rdata;
        kept_d    = kept_q + CntW'(1);
      end
    end

    if (cmd_i.commit) begin
      bank_d  = ~bank_q;
      head_d  = '0;
      count_d = kept_q;
    end

    if (cmd_i.apply) begin
      case (req_q.req_type)
        ccq_pkg::REQ_ENQUEUE: begin
          if (count_q < DepthC) begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
            acc_d   = 1'b1;
          end else begin
            acc_d = 1'b0;
          end
        end
        ccq_pkg::REQ_POP: begin
          if (count_q != '0) begin
            head_d  = next_slot;
            count_d = count_q - CntW'(1);
            acc_d   = 1'b1;
          end else begin
            acc_d = 1'b0;
          end
        end
        ccq_pkg::REQ_CLEAR: begin
          head_d  = '0;
          count_d = '0;
          acc_d   = 1'b1;
        end
        default: begin
          acc_d = 1'b0;
        end
      endcase
    end

    if (cmd_i.rd_head) begin
      ram_re = 1'b1;
    end

    if (cmd_i.load_out) begin
      out_valid_d       = 1'b1;
      out_d.accepted    = acc_q;
      out_d.head_valid  = (count_q != '0);
      out_d.entry_count = CntFw'(count_q);
      if (count_q != '0) begin
        out_d.head_key     = KeyFw'(key_rd);
        out_d.head_payload = PayFw'(pay_rd);
      end else begin
        out_d.head_key     = '0;
        out_d.head_payload = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      bank_q      <= 1'b0;
      rd_idx_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      bank_q      <= bank_d;
      rd_idx_q    <= rd_idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    out_q <= out_d;
  end

  ccq_ram #(
    .Width (EntW),
    .Depth (2 ** AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above queue depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SumW'(head_q) < DepthS)
    else $error("head slot outside queue");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= rd_idx_q)
    else $error("more survivors than entries scanned");

  a_commit_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (head_q == '0) && (bank_q != $past(bank_q)))
    else $error("compaction did not restart at slot zero of the other bank");

endmodule

`default_nettype wire

// File: design/coalescing_command_queue_top.sv
`default_nettype none

// Channel | Direction | Handshake              | Beat payload
// in      | input     | in_valid_i/in_ready_o   | ccq_pkg::in_t  (req_type, key_id, payload_word)
// out     | output    | out_valid_o/out_ready_i | ccq_pkg::out_t (accepted, head, count)
//
// One request is processed at a time. Pop, clear and enqueue on an empty queue
// pass through the apply, head-read and response states; enqueue on a queue of
// n entries first scans them, one entry per cycle read through the entry RAM's single read port.
// Reset empties the queue at once; no clearing pass is needed.
// A result waits in the output register; a stalled output holds the next request
// in the response state until the register frees.

module coalescing_command_queue_top #(
  parameter int unsigned QueueDepth  = ccq_pkg::QueueDepthDef,
  parameter int unsigned KeyBits     = ccq_pkg::KeyBitsDef,
  parameter int unsigned PayloadBits = ccq_pkg::PayloadBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ccq_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ccq_pkg::out_t      out_data_o
);

  ccq_pkg::ctl_cmd_t cmd;
  ccq_pkg::dp_stat_t st;

  ccq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ccq_datapath #(
    .QueueDepth  (QueueDepth),
    .KeyBits     (KeyBits),
    .PayloadBits (PayloadBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
